// ===== rtl/rpc_pkg.sv =====
// rpc_pkg: shared widths, register map, config and sideband types for the radar
// point rotate/clamp pipeline. No dependencies.
package rpc_pkg;

   localparam int COORD_W   = 16;   // input and config words (Q12.4 positions)
   localparam int OUT_W     = 17;   // saturated screen coordinates
   localparam int OFS_W     = 27;   // rotated offset, signed
   localparam int MAG_W     = 26;   // |offset| and floor(sqrt(d2))
   localparam int SQ_W      = 52;   // dx^2 + dz^2
   localparam int SQRT_STEPS = 26;  // one root bit per stage
   localparam int Q_W       = 16;   // quotient never exceeds max_radius
   localparam int NUM_W     = 43;   // |c| * radius + d/2
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   localparam logic signed [OUT_W:0]   OUT_HI = 18'sd65535;
   localparam logic signed [OUT_W:0]   OUT_LO = -18'sd65536;

   typedef enum logic [2:0] {
      REG_VIEWER_X   = 3'd0,
      REG_VIEWER_Z   = 3'd1,
      REG_HEADING_COS = 3'd2,
      REG_HEADING_SIN = 3'd3,
      REG_PIXELS_PER_UNIT = 3'd4,
      REG_MAX_RADIUS = 3'd5,
      REG_CENTER_X   = 3'd6,
      REG_CENTER_Y   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] viewer_x;
      logic [COORD_W-1:0] viewer_z;
      logic [COORD_W-1:0] heading_cos;
      logic [COORD_W-1:0] heading_sin;
      logic [COORD_W-1:0] pixels_per_unit;
      logic [COORD_W-1:0] max_radius;
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
   } cfg_type;

   // sideband that rides alongside the root and divide stages
   typedef struct packed {
      logic [OFS_W-1:0] dx;
      logic [OFS_W-1:0] dz;
      logic             clamp;
   } tag_type;

   function automatic logic [OUT_W-1:0] sat_out(input logic signed [OUT_W+10:0] v);
      logic [OUT_W-1:0] r;
      if (v > (OUT_W+11)'(OUT_HI)) begin
         r = OUT_HI[OUT_W-1:0];
      end else if (v < (OUT_W+11)'(OUT_LO)) begin
         r = OUT_LO[OUT_W-1:0];
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/rpc_req_if.sv =====
// rpc_req_if: input channel carrying one target world position per transfer.
// Depends on rpc_pkg.
interface rpc_req_if import rpc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] target_x;
   logic signed [COORD_W-1:0] target_z;

   modport source (output valid, output target_x, output target_z, input ready);
   modport sink   (input valid, input target_x, input target_z, output ready);
endinterface

// ===== rtl/rpc_rsp_if.sv =====
// rpc_rsp_if: result channel carrying the marker screen position and clamp flag.
// Depends on rpc_pkg.
interface rpc_rsp_if import rpc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] screen_x;
   logic signed [OUT_W-1:0] screen_y;
   logic                    was_clamped;

   modport source (output valid, output screen_x, output screen_y, output was_clamped,
                   input ready);
   modport sink   (input valid, input screen_x, input screen_y, input was_clamped,
                   output ready);
endinterface

// ===== rtl/rpc_front.sv =====
// rpc_front: six-stage front end - offset, pixel scale, rotation, squared distance
// and clamp test. Depends on rpc_pkg.
module rpc_front import rpc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  cfg_type             cfg,
   input  logic                in_valid,
   input  logic [COORD_W-1:0]  target_x,
   input  logic [COORD_W-1:0]  target_z,
   output logic                out_valid,
   output tag_type             out_tag,
   output logic [SQ_W-1:0]     out_d2
);

   logic [5:0] vld_ff;

   // S1: world offset times pixel scale
   logic signed [16:0] wx, wz, ppu_s;
   logic signed [33:0] s1_x_ff, s1_z_ff, s1_x_in, s1_z_in;
   // S2: round to Q12.4 pixels
   logic signed [25:0] s2_x_ff, s2_z_ff, s2_x_in, s2_z_in;
   // S3: rotation products
   logic signed [41:0] s3_xc_ff, s3_xs_ff, s3_zc_ff, s3_zs_ff;
   logic signed [41:0] s3_xc_in, s3_xs_in, s3_zc_in, s3_zs_in;
   // S4: rotated offset
   logic signed [42:0] sum_x, sum_z;
   logic signed [OFS_W-1:0] s4_dx_ff, s4_dz_ff, s4_dx_in, s4_dz_in;
   // S5: squares
   logic [MAG_W-1:0] ax, az;
   logic [SQ_W-1:0]  s5_sx_ff, s5_sz_ff, s5_sx_in, s5_sz_in;
   logic [OFS_W-1:0] s5_dx_ff, s5_dz_ff;
   // S6: distance and test
   logic [SQ_W-1:0]  d2_in, s6_d2_ff;
   logic [31:0]      r2;
   logic             s6_clamp_in, s6_clamp_ff;
   logic [OFS_W-1:0] s6_dx_ff, s6_dz_ff;

   always_comb begin
      wx       = 17'($signed(target_x)) - 17'($signed(cfg.viewer_x));
      wz       = 17'($signed(target_z)) - 17'($signed(cfg.viewer_z));
      ppu_s    = $signed({1'b0, cfg.pixels_per_unit});
      s1_x_in  = 34'(wx) * 34'(ppu_s);
      s1_z_in  = 34'(wz) * 34'(ppu_s);
      s2_x_in  = 26'((s1_x_ff + 34'sd128) >>> 8);
      s2_z_in  = 26'((s1_z_ff + 34'sd128) >>> 8);
      s3_xc_in = 42'(s2_x_ff) * 42'($signed(cfg.heading_cos));
      s3_xs_in = 42'(s2_x_ff) * 42'($signed(cfg.heading_sin));
      s3_zc_in = 42'(s2_z_ff) * 42'($signed(cfg.heading_cos));
      s3_zs_in = 42'(s2_z_ff) * 42'($signed(cfg.heading_sin));
      sum_x    = 43'(s3_xc_ff) - 43'(s3_zs_ff) + 43'sd8192;
      sum_z    = 43'(s3_xs_ff) + 43'(s3_zc_ff) + 43'sd8192;
      s4_dx_in = OFS_W'(sum_x >>> 14);
      s4_dz_in = OFS_W'(sum_z >>> 14);
      ax       = MAG_W'(s4_dx_ff[OFS_W-1] ? -s4_dx_ff : s4_dx_ff);
      az       = MAG_W'(s4_dz_ff[OFS_W-1] ? -s4_dz_ff : s4_dz_ff);
      s5_sx_in = SQ_W'(ax) * SQ_W'(ax);
      s5_sz_in = SQ_W'(az) * SQ_W'(az);
      d2_in    = s5_sx_ff + s5_sz_ff;
      r2       = 32'(cfg.max_radius) * 32'(cfg.max_radius);
      s6_clamp_in = (d2_in > SQ_W'(r2)) && (d2_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff     <= s1_x_in;
         s1_z_ff     <= s1_z_in;
         s2_x_ff     <= s2_x_in;
         s2_z_ff     <= s2_z_in;
         s3_xc_ff    <= s3_xc_in;
         s3_xs_ff    <= s3_xs_in;
         s3_zc_ff    <= s3_zc_in;
         s3_zs_ff    <= s3_zs_in;
         s4_dx_ff    <= s4_dx_in;
         s4_dz_ff    <= s4_dz_in;
         s5_sx_ff    <= s5_sx_in;
         s5_sz_ff    <= s5_sz_in;
         s5_dx_ff    <= s4_dx_ff;
         s5_dz_ff    <= s4_dz_ff;
         s6_d2_ff    <= d2_in;
         s6_clamp_ff <= s6_clamp_in;
         s6_dx_ff    <= s5_dx_ff;
         s6_dz_ff    <= s5_dz_ff;
      end
   end

   assign out_valid     = vld_ff[5];
   assign out_d2        = s6_d2_ff;
   assign out_tag.dx    = s6_dx_ff;
   assign out_tag.dz    = s6_dz_ff;
   assign out_tag.clamp = s6_clamp_ff;

endmodule

// ===== rtl/rpc_sqrt.sv =====
// rpc_sqrt: pipelined integer square root, one result bit per stage.
// Depends on rpc_pkg.
module rpc_sqrt import rpc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [SQ_W-1:0]  in_d2,
   input  tag_type          in_tag,
   output logic             out_valid,
   output logic [MAG_W-1:0] out_root,
   output tag_type          out_tag
);

   logic [SQ_W:0]   n_ff   [SQRT_STEPS];
   logic [SQ_W:0]   res_ff [SQRT_STEPS];
   tag_type         tag_ff [SQRT_STEPS];
   logic            vld_ff [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [SQ_W:0] n_cur, res_cur, n_in, res_in;
      tag_type       tag_cur;
      logic          vld_cur;

      if (k == 0) begin : g_first
         assign n_cur   = {1'b0, in_d2};
         assign res_cur = '0;
         assign tag_cur = in_tag;
         assign vld_cur = in_valid;
      end else begin : g_next
         assign n_cur   = n_ff[k-1];
         assign res_cur = res_ff[k-1];
         assign tag_cur = tag_ff[k-1];
         assign vld_cur = vld_ff[k-1];
      end

      always_comb begin
         if (n_cur >= res_cur + BIT) begin
            n_in   = n_cur - (res_cur + BIT);
            res_in = (res_cur >> 1) + BIT;
         end else begin
            n_in   = n_cur;
            res_in = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k]   <= n_in;
            res_ff[k] <= res_in;
            tag_ff[k] <= tag_cur;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS-1];
   assign out_root  = res_ff[SQRT_STEPS-1][MAG_W-1:0];
   assign out_tag   = tag_ff[SQRT_STEPS-1];

endmodule

// ===== rtl/rpc_div.sv =====
// rpc_div: scales both offset magnitudes by radius / distance with rounding,
// multiply, bias add, then one quotient bit per stage. Depends on rpc_pkg.
module rpc_div import rpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [COORD_W-1:0] max_radius,
   input  logic               in_valid,
   input  logic [MAG_W-1:0]   in_root,
   input  tag_type            in_tag,
   output logic               out_valid,
   output logic [Q_W-1:0]     out_qx,
   output logic [Q_W-1:0]     out_qz,
   output tag_type            out_tag
);

   // M stage: |c| * radius
   logic [MAG_W-1:0] mag_x, mag_z;
   logic [NUM_W-2:0] m_px_ff, m_pz_ff, m_px_in, m_pz_in;
   logic [MAG_W-1:0] m_d_ff, m_d_in;
   tag_type          m_tag_ff;
   // A stage: add half the divisor
   logic [NUM_W-1:0] a_nx_ff, a_nz_ff;
   logic [MAG_W-1:0] a_d_ff;
   tag_type          a_tag_ff;
   logic [1:0]       pre_vld_ff;
   // quotient stages
   logic [NUM_W-1:0] rx_ff [Q_W];
   logic [NUM_W-1:0] rz_ff [Q_W];
   logic [Q_W-1:0]   qx_ff [Q_W];
   logic [Q_W-1:0]   qz_ff [Q_W];
   logic [MAG_W-1:0] d_ff  [Q_W];
   tag_type          tag_ff [Q_W];
   logic             vld_ff [Q_W];

   always_comb begin
      mag_x   = MAG_W'(in_tag.dx[OFS_W-1] ? -in_tag.dx : in_tag.dx);
      mag_z   = MAG_W'(in_tag.dz[OFS_W-1] ? -in_tag.dz : in_tag.dz);
      m_px_in = (NUM_W-1)'(mag_x) * (NUM_W-1)'(max_radius);
      m_pz_in = (NUM_W-1)'(mag_z) * (NUM_W-1)'(max_radius);
      // a zero root only arises on items that are not clamped
      m_d_in  = (in_root == '0) ? MAG_W'(1) : in_root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= '0;
      end else if (en) begin
         pre_vld_ff <= {pre_vld_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_px_ff  <= m_px_in;
         m_pz_ff  <= m_pz_in;
         m_d_ff   <= m_d_in;
         m_tag_ff <= in_tag;
         a_nx_ff  <= NUM_W'(m_px_ff) + NUM_W'(m_d_ff >> 1);
         a_nz_ff  <= NUM_W'(m_pz_ff) + NUM_W'(m_d_ff >> 1);
         a_d_ff   <= m_d_ff;
         a_tag_ff <= m_tag_ff;
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      localparam int SH = Q_W - 1 - k;
      logic [NUM_W-1:0] rx_cur, rz_cur, rx_in, rz_in, sub;
      logic [Q_W-1:0]   qx_cur, qz_cur, qx_in, qz_in;
      logic [MAG_W-1:0] d_cur;
      tag_type          tag_cur;
      logic             vld_cur;

      if (k == 0) begin : g_first
         assign rx_cur  = a_nx_ff;
         assign rz_cur  = a_nz_ff;
         assign qx_cur  = '0;
         assign qz_cur  = '0;
         assign d_cur   = a_d_ff;
         assign tag_cur = a_tag_ff;
         assign vld_cur = pre_vld_ff[1];
      end else begin : g_next
         assign rx_cur  = rx_ff[k-1];
         assign rz_cur  = rz_ff[k-1];
         assign qx_cur  = qx_ff[k-1];
         assign qz_cur  = qz_ff[k-1];
         assign d_cur   = d_ff[k-1];
         assign tag_cur = tag_ff[k-1];
         assign vld_cur = vld_ff[k-1];
      end

      always_comb begin
         sub = NUM_W'(d_cur) << SH;
         if (rx_cur >= sub) begin
            rx_in = rx_cur - sub;
            qx_in = qx_cur | (Q_W'(1) << SH);
         end else begin
            rx_in = rx_cur;
            qx_in = qx_cur;
         end
         if (rz_cur >= sub) begin
            rz_in = rz_cur - sub;
            qz_in = qz_cur | (Q_W'(1) << SH);
         end else begin
            rz_in = rz_cur;
            qz_in = qz_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rx_ff[k]  <= rx_in;
            rz_ff[k]  <= rz_in;
            qx_ff[k]  <= qx_in;
            qz_ff[k]  <= qz_in;
            d_ff[k]   <= d_cur;
            tag_ff[k] <= tag_cur;
         end
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign out_qx    = qx_ff[Q_W-1];
   assign out_qz    = qz_ff[Q_W-1];
   assign out_tag   = tag_ff[Q_W-1];

endmodule

// ===== rtl/radar_point_rotate_clamp.sv =====
// radar_point_rotate_clamp: top level - config registers, pipeline and output register.
// Depends on rpc_pkg, rpc_req_if, rpc_rsp_if, rpc_front, rpc_sqrt, rpc_div.
//
// Usage
//  - req_chan: one target world position (Q12.4) per transfer.
//  - rsp_chan: marker screen position (Q12.4, saturated to 17 bits signed) and a
//    flag set when the offset was pulled back onto max_radius. One result per item,
//    in order.
//  - APB-style register port: register i at byte address 4*i, 16 bits used, read
//    back zero-extended. Write only while the pipeline is empty.
//  - Throughput: one item per cycle while rsp_chan is not stalled. The path from the input
//    transfer to rsp_chan runs through 6 front stages, 26 root stages, 18 scale and
//    divide stages and 1 output register; the 26-stage square root is the longest part.
//  - Reset clears every valid bit and loads the register reset values; no
//    clearing pass, an item can be taken in the first cycle after reset.
//  - Stall: while a result waits and rsp_chan.ready is low the whole pipeline
//    holds; req_chan.ready drops in the same cycle, so nothing is lost or repeated.
//    A taken result frees the output register in the same cycle for the next one.
module radar_point_rotate_clamp import rpc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   rpc_req_if.sink             req_chan,
   rpc_rsp_if.source           rsp_chan,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   cfg_type cfg_ff;
   logic    en;

   // pipeline links
   logic             f_valid, s_valid, d_valid;
   tag_type          f_tag, s_tag, d_tag;
   logic [SQ_W-1:0]  f_d2;
   logic [MAG_W-1:0] s_root;
   logic [Q_W-1:0]   d_qx, d_qz;

   // final offset select and screen position
   logic signed [OFS_W-1:0]   qx_s, qz_s, off_x, off_z;
   logic signed [OUT_W+10:0]  scr_x, scr_z;
   logic                      rsp_valid_ff;
   logic [OUT_W-1:0]          screen_x_ff, screen_y_ff, screen_x_in, screen_y_in;
   logic                      clamped_ff;
   reg_index_type             widx;
   reg_index_type             ridx;
   logic                      wr_hit;

   // whole pipeline moves when the output register is free or being drained
   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // ---------------- register port ----------------
   assign pready = 1'b1;
   assign widx   = reg_index_type'(paddr[ADDR_W-1:2]);
   assign ridx   = widx;
   assign wr_hit = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.viewer_x        <= '0;
         cfg_ff.viewer_z        <= '0;
         cfg_ff.heading_cos     <= 16'd16384;
         cfg_ff.heading_sin     <= '0;
         cfg_ff.pixels_per_unit <= 16'd256;
         cfg_ff.max_radius      <= '0;
         cfg_ff.center_x        <= '0;
         cfg_ff.center_y        <= '0;
      end else if (wr_hit) begin
         case (widx)
            REG_VIEWER_X:        cfg_ff.viewer_x        <= pwdata[COORD_W-1:0];
            REG_VIEWER_Z:        cfg_ff.viewer_z        <= pwdata[COORD_W-1:0];
            REG_HEADING_COS:     cfg_ff.heading_cos     <= pwdata[COORD_W-1:0];
            REG_HEADING_SIN:     cfg_ff.heading_sin     <= pwdata[COORD_W-1:0];
            REG_PIXELS_PER_UNIT: cfg_ff.pixels_per_unit <= pwdata[COORD_W-1:0];
            REG_MAX_RADIUS:      cfg_ff.max_radius      <= pwdata[COORD_W-1:0];
            REG_CENTER_X:        cfg_ff.center_x        <= pwdata[COORD_W-1:0];
            REG_CENTER_Y:        cfg_ff.center_y        <= pwdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         REG_VIEWER_X:        prdata = DATA_W'(cfg_ff.viewer_x);
         REG_VIEWER_Z:        prdata = DATA_W'(cfg_ff.viewer_z);
         REG_HEADING_COS:     prdata = DATA_W'(cfg_ff.heading_cos);
         REG_HEADING_SIN:     prdata = DATA_W'(cfg_ff.heading_sin);
         REG_PIXELS_PER_UNIT: prdata = DATA_W'(cfg_ff.pixels_per_unit);
         REG_MAX_RADIUS:      prdata = DATA_W'(cfg_ff.max_radius);
         REG_CENTER_X:        prdata = DATA_W'(cfg_ff.center_x);
         REG_CENTER_Y:        prdata = DATA_W'(cfg_ff.center_y);
         default:             prdata = '0;
      endcase
   end

   // ---------------- datapath ----------------
   rpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (req_chan.valid),
      .target_x  (req_chan.target_x),
      .target_z  (req_chan.target_z),
      .out_valid (f_valid),
      .out_tag   (f_tag),
      .out_d2    (f_d2)
   );

   rpc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_d2     (f_d2),
      .in_tag    (f_tag),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_tag   (s_tag)
   );

   rpc_div u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .max_radius (cfg_ff.max_radius),
      .in_valid   (s_valid),
      .in_root    (s_root),
      .in_tag     (s_tag),
      .out_valid  (d_valid),
      .out_qx     (d_qx),
      .out_qz     (d_qz),
      .out_tag    (d_tag)
   );

   // clamped items take the rescaled magnitude with the original sign
   always_comb begin
      qx_s  = $signed(OFS_W'(d_qx));
      qz_s  = $signed(OFS_W'(d_qz));
      off_x = $signed(d_tag.dx);
      off_z = $signed(d_tag.dz);
      if (d_tag.clamp) begin
         off_x = d_tag.dx[OFS_W-1] ? -qx_s : qx_s;
         off_z = d_tag.dz[OFS_W-1] ? -qz_s : qz_s;
      end
      scr_x       = $signed((OUT_W+11)'(cfg_ff.center_x)) - (OUT_W+11)'(off_x);
      scr_z       = $signed((OUT_W+11)'(cfg_ff.center_y)) - (OUT_W+11)'(off_z);
      screen_x_in = sat_out(scr_x);
      screen_y_in = sat_out(scr_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         screen_x_ff <= screen_x_in;
         screen_y_ff <= screen_y_in;
         clamped_ff  <= d_tag.clamp;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.screen_x    = $signed(screen_x_ff);
   assign rsp_chan.screen_y    = $signed(screen_y_ff);
   assign rsp_chan.was_clamped = clamped_ff;

endmodule

// ===== rtl/rpc_checker.sv =====
// rpc_checker: port-level assertions for radar_point_rotate_clamp, bound to the top.
// Depends on rpc_pkg and the top level's ports.
module rpc_checker import rpc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [OUT_W-1:0]  screen_x,
   input logic [OUT_W-1:0]  screen_y,
   input logic              was_clamped,
   input logic              psel,
   input logic              penable,
   input logic              pwrite,
   input logic [ADDR_W-1:0] paddr,
   input logic [DATA_W-1:0] pwdata,
   input logic [DATA_W-1:0] prdata
);

   // no result straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input side stalls exactly when a result waits untaken
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready not tied to output stall");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(screen_x) && $stable(screen_y)
         && $stable(was_clamped))
      else $error("stalled result changed");

   // a register reads back what was just written to it
   a_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && paddr[1:0] == 2'b00 ##1
      psel && !pwrite && paddr == $past(paddr)
      |-> prdata[COORD_W-1:0] == $past(pwdata[COORD_W-1:0]))
      else $error("register readback mismatch");

endmodule

bind radar_point_rotate_clamp rpc_checker u_rpc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .screen_x    (rsp_chan.screen_x),
   .screen_y    (rsp_chan.screen_y),
   .was_clamped (rsp_chan.was_clamped),
   .psel        (psel),
   .penable     (penable),
   .pwrite      (pwrite),
   .paddr       (paddr),
   .pwdata      (pwdata),
   .prdata      (prdata)
);
